>>> hw/rtl/upe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the URL percent encoder.
// No dependencies; every other file of the block imports this package.
package upe_pkg;

  // Default depth of the command queue between front and back end.
  localparam int unsigned CmdQueueDepth = 2;

  // Number of output slots one request can expand into.
  localparam int unsigned NumSlots = 7;

  // Slot positions inside a command: escape prefix, held digit, tail.
  localparam int unsigned SlotPfxPct  = 0;
  localparam int unsigned SlotPfxHi   = 1;
  localparam int unsigned SlotPfxLo   = 2;
  localparam int unsigned SlotHeld    = 3;
  localparam int unsigned SlotTail    = 4;
  localparam int unsigned SlotTailHi  = 5;
  localparam int unsigned SlotTailLo  = 6;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChTwo     = 8'h32;
  localparam logic [7:0] ChFive    = 8'h35;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } upe_out_t;

  // One decoded request: which slots to emit, in ascending slot order.
  typedef struct packed {
    logic [NumSlots-1:0] slots;
    logic [7:0]          held;
    logic [7:0]          tail;
    logic                last;
  } upe_cmd_t;

endpackage

>>> hw/rtl/upe_front.sv
`timescale 1ns / 1ps
// Front end: classifies each input byte against the held '%' lookahead
// and turns it into a slot command. Depends on upe_pkg.
module upe_front import upe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  upe_in_t  in_data_i,
  output logic     push_o,
  output upe_cmd_t cmd_o
);

  logic       pct_q, pct_d;
  logic       la_q, la_d;
  logic [7:0] la_byte_q, la_byte_d;

  logic [7:0] b;
  logic       last;
  logic       b_hex, b_plain;
  logic       f_en, f_esc, f_pct;
  logic       t_en, t_esc, held_en, pfx25, pfx_pct;

  function automatic logic is_hex(input logic [7:0] v);
    logic [7:0] low;
    low = v | 8'h20;
    return (v >= 8'h30 && v <= 8'h39) || (low > 8'd96 && low < 8'd103);
  endfunction

  function automatic logic is_plain(input logic [7:0] v);
    logic r;
    r = (v >= 8'h61 && v <= 8'h7a) || (v >= 8'h41 && v <= 8'h5a) ||
        (v >= 8'h30 && v <= 8'h39);
    case (v)
      8'h2f, 8'h3a, 8'h5f, 8'h2e, 8'h2d, 8'h3f, 8'h3d, 8'h26: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  assign b       = in_data_i.in_byte;
  assign last    = in_data_i.in_last;
  assign b_hex   = is_hex(b);
  assign b_plain = is_plain(b);

  // Fresh byte handling: hold a '%' unless it ends the text.
  always_comb begin
    f_en  = 1'b0;
    f_esc = 1'b0;
    f_pct = 1'b0;
    if (b == ChPercent) begin
      if (last) begin
        f_en  = 1'b1;
        f_esc = 1'b1;
      end else begin
        f_pct = 1'b1;
      end
    end else if (b_plain) begin
      f_en = 1'b1;
    end else begin
      f_en  = 1'b1;
      f_esc = 1'b1;
    end
  end

  always_comb begin
    pct_d     = pct_q;
    la_d      = la_q;
    la_byte_d = la_byte_q;
    t_en      = 1'b0;
    t_esc     = 1'b0;
    held_en   = 1'b0;
    pfx25     = 1'b0;
    pfx_pct   = 1'b0;
    if (accept_i) begin
      if (!pct_q) begin
        t_en  = f_en;
        t_esc = f_esc;
        pct_d = f_pct;
        la_d  = 1'b0;
      end else if (!la_q) begin
        if (b_hex && !last) begin
          la_d      = 1'b1;
          la_byte_d = b;
        end else begin
          pfx25 = 1'b1;
          t_en  = f_en;
          t_esc = f_esc;
          pct_d = f_pct;
        end
      end else begin
        la_d    = 1'b0;
        held_en = 1'b1;
        if (b_hex) begin
          pfx_pct = 1'b1;
          t_en    = 1'b1;
          pct_d   = 1'b0;
        end else begin
          pfx25 = 1'b1;
          t_en  = f_en;
          t_esc = f_esc;
          pct_d = f_pct;
        end
      end
      if (last) begin
        pct_d     = 1'b0;
        la_d      = 1'b0;
        la_byte_d = '0;
      end
    end
  end

  always_comb begin
    cmd_o.slots             = '0;
    cmd_o.slots[SlotPfxPct] = pfx25 | pfx_pct;
    cmd_o.slots[SlotPfxHi]  = pfx25;
    cmd_o.slots[SlotPfxLo]  = pfx25;
    cmd_o.slots[SlotHeld]   = held_en;
    cmd_o.slots[SlotTail]   = t_en;
    cmd_o.slots[SlotTailHi] = t_en & t_esc;
    cmd_o.slots[SlotTailLo] = t_en & t_esc;
    cmd_o.held              = la_byte_q;
    cmd_o.tail              = b;
    cmd_o.last              = last;
  end

  assign push_o = accept_i && (cmd_o.slots != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q     <= 1'b0;
      la_q      <= 1'b0;
      la_byte_q <= '0;
    end else begin
      pct_q     <= pct_d;
      la_q      <= la_d;
      la_byte_q <= la_byte_d;
    end
  end

endmodule

>>> hw/rtl/upe_fifo.sv
`timescale 1ns / 1ps
// Small command queue between front and back end, registers only.
// Depends on upe_pkg for the command type.
module upe_fifo import upe_pkg::*; #(
  parameter int unsigned Depth = CmdQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  upe_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output upe_cmd_t pop_data_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  upe_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/upe_back.sv
`timescale 1ns / 1ps
// Back end: walks the slots of one command, one output byte per cycle
// while the output is not stalled, into the output register. Depends on upe_pkg.
module upe_back import upe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_empty_i,
  input  upe_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output upe_out_t out_data_o
);

  upe_cmd_t            cur_q, cur_d;
  logic [NumSlots-1:0] mask_q, mask_d;
  logic [NumSlots-1:0] sel, rest;
  logic [7:0]          vals [NumSlots];
  logic [7:0]          byte_sel;
  logic                slot_free, emit, run_done, load;
  logic                out_valid_q, out_valid_d;
  upe_out_t            out_q, out_d;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
  endfunction

  always_comb begin
    vals[SlotPfxPct] = ChPercent;
    vals[SlotPfxHi]  = ChTwo;
    vals[SlotPfxLo]  = ChFive;
    vals[SlotHeld]   = cur_q.held;
    vals[SlotTail]   = mask_q[SlotTailHi] ? ChPercent : cur_q.tail;
    vals[SlotTailHi] = hex_char(cur_q.tail[7:4]);
    vals[SlotTailLo] = hex_char(cur_q.tail[3:0]);
  end

  // Lowest pending slot goes out next.
  assign sel  = mask_q & (~mask_q + 1'b1);
  assign rest = mask_q & ~sel;

  always_comb begin
    byte_sel = '0;
    for (int i = 0; i < NumSlots; i++) begin
      byte_sel = byte_sel | ({8{sel[i]}} & vals[i]);
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = (mask_q != '0) && slot_free;
  assign run_done  = emit && (rest == '0);
  assign load      = (mask_q == '0) || run_done;
  assign pop_o     = load && !cmd_empty_i;

  always_comb begin
    mask_d = mask_q;
    cur_d  = cur_q;
    if (pop_o) begin
      mask_d = cmd_i.slots;
      cur_d  = cmd_i;
    end else if (emit) begin
      mask_d = rest;
    end
  end

  always_comb begin
    out_valid_d = slot_free ? emit : out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_d.out_byte = byte_sel;
      out_d.run_end  = (rest == '0);
      out_d.text_end = (rest == '0) && cur_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/url_percent_encoder_top.sv
`timescale 1ns / 1ps
// URL percent encoder, top level: front end, command queue, back end.
// Depends on upe_pkg, upe_front, upe_fifo and upe_back.

// The block takes one text byte per request on the input channel and gives
// the encoded text one byte per request on the output channel. Letters,
// digits and / : _ . - ? = & pass unchanged; a '%' followed by two hex
// digits passes as is, any other '%' becomes "%25"; every other byte,
// zero included, becomes '%' and two lower-case hex digits. A '%' and up
// to one hex digit after it are held back and produce no output until
// the block can decide; in_last flushes them. run_end marks the last
// output byte of an input request, text_end the last byte of the whole
// text. An input byte produces one output byte if plain, three for an
// escape, up to seven when a held '%' fails. The back end's single output
// register gives one byte per clock while out_ready_i takes it; the front
// end takes an input in every cycle in which the command queue
// (QueueDepth entries, two by default) has room, also while a result
// waits at the output.
module url_percent_encoder_top import upe_pkg::*; #(
  parameter int unsigned QueueDepth = CmdQueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  upe_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output upe_out_t out_data_o
);

  logic     accept;
  logic     push;
  logic     pop;
  logic     q_full, q_empty;
  upe_cmd_t front_cmd;
  upe_cmd_t back_cmd;

  // Accept whenever the queue has room; the front end never stalls itself.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the byte and build its slot command; hold lookahead state.
  upe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .cmd_o     (front_cmd)
  );

  // Decouple the two sides so each can stall on its own.
  upe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (back_cmd),
    .empty_o     (q_empty)
  );

  // Expand commands into output bytes, one per cycle while the output is ready.
  upe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/upe_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the URL percent encoder, bound to the top level.
// Depends on upe_pkg and url_percent_encoder_top.
module upe_checker import upe_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input upe_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input upe_out_t out_data_o
);

  logic [7:0] ob;
  logic       byte_ok;

  // Every encoded byte is a plain character or '%'.
  assign ob      = out_data_o.out_byte;
  assign byte_ok = (ob >= 8'h61 && ob <= 8'h7a) || (ob >= 8'h41 && ob <= 8'h5a) ||
                   (ob >= 8'h30 && ob <= 8'h39) || ob == 8'h2f || ob == 8'h3a ||
                   ob == 8'h5f || ob == 8'h2e || ob == 8'h2d || ob == 8'h3f ||
                   ob == 8'h3d || ob == 8'h26 || ob == ChPercent;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input request dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_text_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.text_end |-> out_data_o.run_end)
    else $error("text end without run end");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_ok)
    else $error("unescaped byte on output");

endmodule

bind url_percent_encoder_top upe_checker u_upe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> sim/url_percent_encoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_encoder_top: directed texts, then random texts.
// Depends on upe_pkg and the encoder RTL; a scoreboard class predicts every output byte.
module url_percent_encoder_top_tb;
  import upe_pkg::*;

  // Hard stop for a hung block, well above the slowest legal run.
  localparam int unsigned CycleLimit = 200000;
  // Cycles to watch for stray output once nothing is expected any more.
  localparam int unsigned TailCycles = 20;

  // Predicts the encoded stream and checks each output request against it.
  class upe_scoreboard;
    upe_out_t    expected_bytes[$];
    upe_out_t    run_bytes[$];
    logic        pct_held;
    logic        digit_held;
    logic [7:0]  held_digit;
    int unsigned errors;

    function new();
      pct_held   = 1'b0;
      digit_held = 1'b0;
      held_digit = '0;
      errors     = 0;
    endfunction

    function bit is_hex(logic [7:0] b);
      logic [7:0] lower;
      lower = b | 8'h20;
      return (b >= "0" && b <= "9") || (lower >= "a" && lower <= "f");
    endfunction

    function bit is_plain(logic [7:0] b);
      if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))
        return 1'b1;
      case (b)
        "/", ":", "_", ".", "-", "?", "=", "&": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Lower-case hex digit for one nibble.
    function logic [7:0] hex_char(logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h57 + 8'(nib);
    endfunction

    function void push_byte(logic [7:0] b);
      upe_out_t item;
      item.out_byte = b;
      item.run_end  = 1'b0;
      item.text_end = 1'b0;
      run_bytes.insert(run_bytes.size(), item);
    endfunction

    function void push_escaped(logic [7:0] b);
      push_byte(ChPercent);
      push_byte(hex_char(b[7:4]));
      push_byte(hex_char(b[3:0]));
    endfunction

    // Handle a byte with nothing held in front of it.
    function void accept_fresh(logic [7:0] b, logic last);
      if (b == ChPercent) begin
        if (!last) begin
          pct_held   = 1'b1;
          digit_held = 1'b0;
        end else begin
          push_escaped(b);
        end
      end else if (is_plain(b)) begin
        push_byte(b);
      end else begin
        push_escaped(b);
      end
    endfunction

    // Note one accepted input request and queue the output bytes it causes.
    function void note_request(upe_in_t req);
      logic [7:0] b;
      logic       last;
      logic [7:0] prev_digit;
      b    = req.in_byte;
      last = req.in_last;
      run_bytes.delete();
      if (!pct_held) begin
        accept_fresh(b, last);
      end else if (!digit_held) begin
        if (is_hex(b) && !last) begin
          digit_held = 1'b1;
          held_digit = b;
        end else begin
          pct_held = 1'b0;
          push_escaped(ChPercent);
          accept_fresh(b, last);
        end
      end else begin
        prev_digit = held_digit;
        pct_held   = 1'b0;
        digit_held = 1'b0;
        held_digit = '0;
        if (is_hex(b)) begin
          push_byte(ChPercent);
          push_byte(prev_digit);
          push_byte(b);
        end else begin
          push_escaped(ChPercent);
          push_byte(prev_digit);
          accept_fresh(b, last);
        end
      end
      if (last) begin
        pct_held   = 1'b0;
        digit_held = 1'b0;
        held_digit = '0;
      end
      if (run_bytes.size() > 0) begin
        run_bytes[run_bytes.size() - 1].run_end  = 1'b1;
        run_bytes[run_bytes.size() - 1].text_end = last;
      end
      foreach (run_bytes[k]) expected_bytes.insert(expected_bytes.size(), run_bytes[k]);
    endfunction

    // Compare one accepted output request with the oldest prediction.
    function void check_result(upe_out_t got);
      upe_out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: expected no output, actual byte=%02h run_end=%0b text_end=%0b",
                 $time, got.out_byte, got.run_end, got.text_end);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %02h actual %02h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.run_end !== want.run_end) begin
        errors++;
        $display("%0t: run_end expected %0b actual %0b", $time, want.run_end, got.run_end);
      end
      if (got.text_end !== want.text_end) begin
        errors++;
        $display("%0t: text_end expected %0b actual %0b",
                 $time, want.text_end, got.text_end);
      end
    endfunction

    function int unsigned outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  upe_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  upe_out_t out_data_o;

  upe_scoreboard sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   requests_sent;
  int unsigned   cycle_count;

  url_percent_encoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout: count cycles and give up once the limit is hit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[url_percent_encoder_top] ERROR");
    $finish;
  end

  // Receiver: pick the ready level for the next edge at every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: sample both handshakes at the rising edge. The input is noted
  // first; the command queue and the output register lie between input and
  // output, so an output accepted at the same edge never stems from this input request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // Drive one input request. Enter and leave at a falling edge; valid stays
  // high on exit so back-to-back requests never drop it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, in_last: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input idle until every predicted byte has come out.
  task automatic wait_drained();
    do begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end while (sb.outstanding() != 0);
  endtask

  function automatic logic [7:0] pick_hex();
    case ($urandom_range(2))
      0:       return 8'("0") + 8'($urandom_range(9));
      1:       return 8'("a") + 8'($urandom_range(5));
      default: return 8'("A") + 8'($urandom_range(5));
    endcase
  endfunction

  // Bias toward percent signs and hex digits so the lookahead gets exercised;
  // the rest is any byte at all.
  function automatic logic [7:0] pick_text_byte();
    string       marks;
    int unsigned roll;
    marks = "/:_.-?=&";
    roll  = $urandom_range(99);
    if (roll < 25) return ChPercent;
    if (roll < 50) return pick_hex();
    if (roll < 60) return marks[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  // One text: mostly well-formed escapes with random bytes in between,
  // always closed by in_last so nothing stays held.
  task automatic send_text(input int unsigned max_len);
    int unsigned len;
    int unsigned k;
    len = $urandom_range(1, max_len);
    k   = 0;
    while (k < len) begin
      if ($urandom_range(99) < 35 && k + 3 <= len) begin
        send_byte(ChPercent, 1'b0);
        send_byte(pick_hex(), 1'b0);
        send_byte(pick_hex(), k + 3 == len);
        k += 3;
      end else begin
        send_byte(pick_text_byte(), k + 1 == len);
        k++;
      end
    end
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned send_pct,
                           input int unsigned recv_pct, input bit with_pause);
    int unsigned start;
    bit          paused;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start  = requests_sent;
    paused = 1'b0;
    while (requests_sent - start < count) begin
      send_text(10);
      // Stop sending midway and let the output run dry once.
      if (with_pause && !paused && requests_sent - start >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    requests_sent = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed texts under the first idle mix.
    send_idle_pct = 23;
    recv_idle_pct = 56;
    send_byte(8'h00, 1'b0);       // zero byte is escaped, text goes on
    send_byte(8'hff, 1'b0);       // top byte value
    send_byte(8'h80, 1'b0);
    send_byte("a", 1'b0);
    send_byte("-", 1'b0);
    send_byte(ChPercent, 1'b0);   // held, no output yet
    send_byte("A", 1'b0);         // held digit
    send_byte("f", 1'b0);         // valid escape passes as is
    send_byte(ChPercent, 1'b0);
    send_byte(ChPercent, 1'b0);   // first one fails, second takes its place
    send_byte("g", 1'b0);         // not hex: failed percent, then plain byte
    send_byte(ChPercent, 1'b0);
    send_byte("9", 1'b0);
    send_byte(" ", 1'b0);         // widest expansion: seven output bytes
    send_byte(ChPercent, 1'b1);   // percent as the final byte
    send_byte(ChPercent, 1'b0);
    send_byte("B", 1'b0);
    send_byte("~", 1'b1);         // held percent and digit flushed at the end
    send_byte(ChPercent, 1'b0);
    send_byte("c", 1'b1);         // hex digit but final: percent fails
    send_byte("Z", 1'b1);         // one-byte text
    send_byte(ChPercent, 1'b0);
    send_byte("1", 1'b0);
    send_byte("2", 1'b1);         // valid escape closes the text
    send_byte("&", 1'b1);

    // Random texts over three idle mixes.
    run_phase(50, 23, 56, 1'b1);
    run_phase(50, 56, 23, 1'b0);
    run_phase(50, 0, 0, 1'b0);

    // Drain, then watch a little longer for stray output.
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[url_percent_encoder_top] OK");
    end else begin
      $display("[url_percent_encoder_top] ERROR");
    end
    $finish;
  end

endmodule
